// ----- rtl/core/scaled_glyph_blitter_assert.svh -----
// Assertion macros shared by the scaled glyph blitter checker.
`ifndef SCALED_GLYPH_BLITTER_ASSERT_SVH
`define SCALED_GLYPH_BLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scaled_glyph_blitter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scaled_glyph_blitter: next-cycle check failed");

`endif

// ----- rtl/core/sgb_pkg.sv -----
// Package with the item types and fixed constants of the scaled glyph blitter.
`timescale 1ns / 1ps

package sgb_pkg;

    localparam int GLYPH_DIM = 8;
    localparam int COLOR_W = 16;
    localparam int ADDR_W = 32;
    localparam int SCALE_W = 4;
    localparam int COORD_W = 10;
    localparam int GLYPH_W = 7;
    localparam int ROW_W = 3;
    // Screen line of a glyph row: origin plus up to seven rows of eight lines.
    localparam int LINE_Y_W = 11;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [GLYPH_W-1:0]       glyph_index;
        logic [ROW_W-1:0]         row_index;
        logic [GLYPH_DIM-1:0]     row_bits;
        logic [COORD_W-1:0]       origin_x;
        logic [COORD_W-1:0]       origin_y;
        logic [SCALE_W-1:0]       scale;
        logic [COLOR_W-1:0]       back_color;
        logic [COLOR_W-1:0]       fg_color;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]        pixel_address;
        logic [COLOR_W-1:0]       span_color;
        logic [SCALE_W-1:0]       run_length;
        logic                     off_screen;
        logic                     last;
    } out_item_t;

endpackage

// ----- rtl/core/sgb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module sgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/scaled_glyph_blitter.sv -----
// Top level of the scaled glyph blitter: font store, span sequencer and output register.
//
// Usage. Input items arrive on in_valid/in_item and are taken at an edge where
// in_valid is high and in_stall is low. A load item (func = load) writes one
// font row into the store and produces nothing; the block is ready again in
// the next cycle. A draw item produces scale*8 spans (scale saturates at MAX_SCALE)
// on out_valid/out_item, top screen line first and glyph column 0 first within a line,
// with last set on the final span. A draw with scale 0 produces nothing.
// A draw is accepted while its font row is read, passes the setup states S_PREP
// (font row latched, screen line) and S_ORIGIN (line address), then issues one
// span per cycle while out_stall does not hold the output register. The single
// offset adder of the sequencer, shared between the column step and the line
// step, sets the one-span-per-cycle pace. in_stall is high from the cycle after a draw
// with nonzero scale is accepted until its last span has entered the output register.
// When out_stall holds the output register, the sequencer waits and the span
// in the register stays unchanged. A new item can be accepted while the last
// span of the previous draw still waits to be taken.
// Reset clears the state machine, the output valid flag and frame_base. The font store is
// not cleared; a row must be loaded before it is drawn. The user must write frame_base
// through cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps

module scaled_glyph_blitter #(
    parameter int SCREEN_W = 1024,
    parameter int SCREEN_H = 1024,
    parameter int GLYPH_COUNT = 128,
    parameter int MAX_SCALE = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sgb_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output sgb_pkg::out_item_t out_item,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data
);

    // Font store geometry.
    localparam int STORE_DEPTH = GLYPH_COUNT * sgb_pkg::GLYPH_DIM;
    localparam int STORE_AW = $clog2(STORE_DEPTH);
    localparam int RAW_AW = sgb_pkg::GLYPH_W + sgb_pkg::ROW_W;
    localparam int FULL_AW = (STORE_AW > RAW_AW) ? STORE_AW : RAW_AW;
    localparam int GC_W = $clog2(GLYPH_COUNT + 1);
    localparam int GCMP_W = (GC_W > sgb_pkg::GLYPH_W) ? GC_W : sgb_pkg::GLYPH_W;

    // Linear pixel offset: the largest offset stays below 2048 * SCREEN_W.
    localparam int OFF_W = sgb_pkg::LINE_Y_W + $clog2(SCREEN_W);
    localparam int LIMIT = SCREEN_W * SCREEN_H;
    localparam int LIM_W = $clog2(LIMIT + 1);
    localparam int CMP_W = (OFF_W > LIM_W) ? OFF_W : LIM_W;

    localparam int LAST_COL = sgb_pkg::GLYPH_DIM - 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_ORIGIN,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    // Configuration.
    logic [31:0] frame_base_reg;

    // Latched draw parameters.
    logic                           glyph_ok_reg, glyph_ok_next;
    logic [sgb_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [sgb_pkg::COORD_W-1:0]    ox_reg, ox_next;
    logic [sgb_pkg::COORD_W-1:0]    oy_reg, oy_next;
    logic [sgb_pkg::SCALE_W-1:0]    scale_reg, scale_next;
    logic [sgb_pkg::COLOR_W-1:0]    bg_reg, bg_next;
    logic [sgb_pkg::COLOR_W-1:0]    fg_reg, fg_next;
    logic [sgb_pkg::GLYPH_DIM-1:0]  pattern_reg, pattern_next;

    // Sequencer.
    logic [sgb_pkg::LINE_Y_W-1:0]   y_reg, y_next;
    logic [OFF_W-1:0]               line_off_reg, line_off_next;
    logic [OFF_W-1:0]               span_off_reg, span_off_next;
    logic [sgb_pkg::ROW_W-1:0]      col_reg, col_next;
    logic [sgb_pkg::ROW_W-1:0]      line_cnt_reg, line_cnt_next;

    // Output register.
    logic                           out_valid_reg, out_valid_next;
    sgb_pkg::out_item_t             out_item_reg, out_item_next;

    // Combinational helpers.
    logic                           in_accept;
    logic                           is_draw;
    logic                           glyph_in_range;
    logic [sgb_pkg::SCALE_W-1:0]    scale_sat;
    logic [FULL_AW-1:0]             store_addr_full;
    logic [STORE_AW-1:0]            store_addr;
    logic [sgb_pkg::GLYPH_DIM-1:0]  store_rd_data;
    logic                           emit;
    logic                           col_last;
    logic                           line_last;
    logic [OFF_W-1:0]               add_a;
    logic [OFF_W-1:0]               add_b;
    logic [OFF_W-1:0]               add_sum;

    assign in_stall = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign is_draw = (in_item.func == sgb_pkg::FUNC_DRAW);
    assign glyph_in_range = (GCMP_W'(in_item.glyph_index) < GCMP_W'(GLYPH_COUNT));

    // Scales above the maximum saturate.
    assign scale_sat = (in_item.scale > sgb_pkg::SCALE_W'(MAX_SCALE))
                       ? sgb_pkg::SCALE_W'(MAX_SCALE) : in_item.scale;

    assign store_addr_full = FULL_AW'({in_item.glyph_index, in_item.row_index});
    assign store_addr = store_addr_full[STORE_AW-1:0];

    sgb_ram #(
        .WIDTH (sgb_pkg::GLYPH_DIM),
        .DEPTH (STORE_DEPTH)
    ) u_font_store (
        .clk     (clk),
        .wr_en   (in_accept && !is_draw && glyph_in_range),
        .wr_addr (store_addr),
        .wr_data (in_item.row_bits),
        .rd_en   (in_accept && is_draw),
        .rd_addr (store_addr),
        .rd_data (store_rd_data)
    );

    // The shared offset adder steps one column along a line, or at the end of a
    // line jumps from the line start to the start of the next screen line.
    assign col_last = (col_reg == sgb_pkg::ROW_W'(LAST_COL));
    assign line_last = ({1'b0, line_cnt_reg} == (scale_reg - sgb_pkg::SCALE_W'(1)));
    assign add_a = col_last ? line_off_reg : span_off_reg;
    assign add_b = col_last ? OFF_W'(SCREEN_W) : OFF_W'(scale_reg);
    assign add_sum = add_a + add_b;

    assign emit = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        glyph_ok_next = glyph_ok_reg;
        row_next = row_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        scale_next = scale_reg;
        bg_next = bg_reg;
        fg_next = fg_reg;
        pattern_next = pattern_reg;
        y_next = y_reg;
        line_off_next = line_off_reg;
        span_off_next = span_off_reg;
        col_next = col_reg;
        line_cnt_next = line_cnt_reg;
        out_valid_next = out_valid_reg;
        out_item_next = out_item_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && is_draw)
                begin
                    glyph_ok_next = glyph_in_range;
                    row_next = in_item.row_index;
                    ox_next = in_item.origin_x;
                    oy_next = in_item.origin_y;
                    scale_next = scale_sat;
                    bg_next = in_item.back_color;
                    fg_next = in_item.fg_color;
                    if (scale_sat != '0)
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                // Font row is on the RAM output now; glyphs beyond the store draw only the background colour.
                pattern_next = glyph_ok_reg ? store_rd_data : '0;
                y_next = sgb_pkg::LINE_Y_W'(oy_reg)
                         + sgb_pkg::LINE_Y_W'(row_reg) * sgb_pkg::LINE_Y_W'(scale_reg);
                state_next = S_ORIGIN;
            end
            S_ORIGIN:
            begin
                line_off_next = OFF_W'(y_reg) * OFF_W'(SCREEN_W) + OFF_W'(ox_reg);
                span_off_next = OFF_W'(y_reg) * OFF_W'(SCREEN_W) + OFF_W'(ox_reg);
                col_next = '0;
                line_cnt_next = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_item_next.pixel_address = frame_base_reg + 32'(span_off_reg);
                    out_item_next.span_color = pattern_reg[col_reg] ? fg_reg : bg_reg;
                    out_item_next.run_length = scale_reg;
                    out_item_next.off_screen = (CMP_W'(span_off_reg) >= CMP_W'(LIMIT));
                    out_item_next.last = col_last && line_last;

                    span_off_next = add_sum;
                    col_next = col_reg + sgb_pkg::ROW_W'(1);
                    if (col_last)
                    begin
                        line_off_next = add_sum;
                        line_cnt_next = line_cnt_reg + sgb_pkg::ROW_W'(1);
                        if (line_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_item_reg <= '0;
            frame_base_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            out_item_reg <= out_item_next;
            if (cfg_wr_en)
            begin
                frame_base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_ok_reg <= glyph_ok_next;
        row_reg <= row_next;
        ox_reg <= ox_next;
        oy_reg <= oy_next;
        scale_reg <= scale_next;
        bg_reg <= bg_next;
        fg_reg <= fg_next;
        pattern_reg <= pattern_next;
        y_reg <= y_next;
        line_off_reg <= line_off_next;
        span_off_reg <= span_off_next;
        col_reg <= col_next;
        line_cnt_reg <= line_cnt_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;

endmodule

// ----- rtl/core/sgb_checker.sv -----
// Port-level checker for the scaled glyph blitter and its bind statement.
`timescale 1ns / 1ps
`include "scaled_glyph_blitter_assert.svh"

module sgb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input sgb_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_stall,
    input sgb_pkg::out_item_t out_item
);

    logic in_accept;
    logic draws;

    assign in_accept = in_valid && !in_stall;
    assign draws = (in_item.func == sgb_pkg::FUNC_DRAW) && (in_item.scale != '0);

    // A held span must stay put while the receiver stalls.
    `SGB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_item))

    // A draw that produces spans makes the block busy in the next cycle.
    `SGB_ASSERT_NEXT(a_draw_busy, clk, rst_n, in_accept && draws, in_stall)

    // Loads and empty draws leave the block ready for the next item.
    `SGB_ASSERT_NEXT(a_load_ready, clk, rst_n, in_accept && !draws, !in_stall)

    // Every span has a length between one and the glyph width.
    `SGB_ASSERT_NOW(a_run_len, clk, rst_n, out_valid,
        (out_item.run_length != '0)
        && (out_item.run_length <= sgb_pkg::SCALE_W'(sgb_pkg::GLYPH_DIM)))

endmodule

bind scaled_glyph_blitter sgb_checker u_sgb_checker (.*);
